### design/evt3_pkg.sv
package evt3_pkg;

    // Width of the high-half wrap counter.
    localparam int WRAP_BITS = 16;

    localparam int WORD_W  = 16;
    localparam int TYPE_W  = 4;
    localparam int PAY_W   = 12;
    localparam int COL_W   = 11;
    localparam int HALF_W  = 12;
    localparam int TS_W    = 40;
    localparam int MASK_W  = 12;
    localparam int IDX_W   = 4;

    localparam logic [COL_W-1:0] VECT12_STEP = 11'd12;
    localparam logic [COL_W-1:0] VECT8_STEP  = 11'd8;

    typedef enum logic [TYPE_W-1:0] {
        T_ADDR_Y      = 4'h0,
        T_ADDR_X      = 4'h2,
        T_VECT_BASE_X = 4'h3,
        T_VECT_12     = 4'h4,
        T_VECT_8      = 4'h5,
        T_TIME_LOW    = 4'h6,
        T_CONTINUED4  = 4'h7,
        T_TIME_HIGH   = 4'h8,
        T_EXT_TRIGGER = 4'hA,
        T_OTHERS      = 4'hE,
        T_CONTINUED12 = 4'hF
    } t_word_type;

    typedef enum logic {
        K_EVENT = 1'b0,
        K_ERROR = 1'b1
    } t_kind;

    // One decoded word waiting to be drained, one result per set mask bit.
    typedef struct packed {
        logic                valid;
        t_kind               kind;
        logic [MASK_W-1:0]   mask;
        logic [COL_W-1:0]    base;
        logic                polarity;
        logic [COL_W-1:0]    row;
        logic [TS_W-1:0]     timestamp;
        logic [TYPE_W-1:0]   error_type;
    } t_job;

    // Index of the lowest set bit; zero for an empty mask.
    function automatic logic [IDX_W-1:0] lsb_index(input logic [MASK_W-1:0] mask);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int b = MASK_W - 1; b >= 0; b--) begin
            if (mask[b]) begin
                idx = IDX_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

### design/evt3_dec_state.sv
module evt3_dec_state (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [evt3_pkg::WORD_W-1:0]  i_word,
    output evt3_pkg::t_job               o_job
);

    logic [evt3_pkg::COL_W-1:0]     r_row, n_row;
    logic [evt3_pkg::COL_W-1:0]     r_base, n_base;
    logic                           r_pol, n_pol;
    logic [evt3_pkg::HALF_W-1:0]    r_low, n_low;
    logic [evt3_pkg::HALF_W-1:0]    r_high, n_high;
    logic [evt3_pkg::WRAP_BITS-1:0] r_wrap, n_wrap;

    logic [evt3_pkg::TYPE_W-1:0] w_type;
    logic [evt3_pkg::PAY_W-1:0]  w_pay;
    logic [evt3_pkg::TS_W-1:0]   w_stamp;

    assign w_type = i_word[evt3_pkg::WORD_W-1 -: evt3_pkg::TYPE_W];
    assign w_pay  = i_word[evt3_pkg::PAY_W-1:0];

    assign w_stamp = (evt3_pkg::TS_W'(r_wrap) << 24)
                   + (evt3_pkg::TS_W'(r_high) << 12)
                   + evt3_pkg::TS_W'(r_low);

    always_comb begin
        n_row  = r_row;
        n_base = r_base;
        n_pol  = r_pol;
        n_low  = r_low;
        n_high = r_high;
        n_wrap = r_wrap;

        o_job            = '0;
        o_job.kind       = evt3_pkg::K_EVENT;
        o_job.base       = r_base;
        o_job.polarity   = r_pol;
        o_job.row        = r_row;
        o_job.timestamp  = w_stamp;

        unique case (w_type)
            evt3_pkg::T_ADDR_Y: begin
                n_row = w_pay[evt3_pkg::COL_W-1:0];
            end
            evt3_pkg::T_ADDR_X: begin
                o_job.valid    = 1'b1;
                o_job.mask     = evt3_pkg::MASK_W'(1);
                o_job.base     = w_pay[evt3_pkg::COL_W-1:0];
                o_job.polarity = w_pay[evt3_pkg::PAY_W-1];
            end
            evt3_pkg::T_VECT_BASE_X: begin
                n_base = w_pay[evt3_pkg::COL_W-1:0];
                n_pol  = w_pay[evt3_pkg::PAY_W-1];
            end
            evt3_pkg::T_VECT_12: begin
                o_job.valid = |w_pay;
                o_job.mask  = w_pay;
                n_base      = r_base + evt3_pkg::VECT12_STEP;
            end
            evt3_pkg::T_VECT_8: begin
                o_job.valid = |w_pay[7:0];
                o_job.mask  = {4'b0, w_pay[7:0]};
                n_base      = r_base + evt3_pkg::VECT8_STEP;
            end
            evt3_pkg::T_TIME_LOW: begin
                n_low = w_pay;
            end
            evt3_pkg::T_TIME_HIGH: begin
                if (w_pay < r_high) begin
                    n_wrap = r_wrap + evt3_pkg::WRAP_BITS'(1);
                end
                n_high = w_pay;
            end
            evt3_pkg::T_CONTINUED4, evt3_pkg::T_EXT_TRIGGER,
            evt3_pkg::T_OTHERS, evt3_pkg::T_CONTINUED12: begin
            end
            default: begin
                // unknown type: a single error result, state untouched
                o_job.valid      = 1'b1;
                o_job.kind       = evt3_pkg::K_ERROR;
                o_job.mask       = evt3_pkg::MASK_W'(1);
                o_job.base       = '0;
                o_job.polarity   = 1'b0;
                o_job.row        = '0;
                o_job.timestamp  = '0;
                o_job.error_type = w_type;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_base <= '0;
            r_pol  <= 1'b0;
            r_low  <= '0;
            r_high <= '0;
            r_wrap <= '0;
        end else if (i_accept) begin
            r_row  <= n_row;
            r_base <= n_base;
            r_pol  <= n_pol;
            r_low  <= n_low;
            r_high <= n_high;
            r_wrap <= n_wrap;
        end
    end

endmodule

### design/evt3_event_word_decoder_core.sv
// A word's results pass first through the pending job register and then the output register.
// Throughput: one word per cycle while the output is not stalled; a vector word holds the
//   input until each set mask bit (up to twelve) has been drained, one event per cycle.
// Words that give no result (row, base, time, ignored types) do not hold the input.
// Reset (i_rst_n low, synchronous) clears row, base column, polarity, both time
//   halves, the wrap count, the pending word and the output valid flag.
module evt3_event_word_decoder_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [evt3_pkg::WORD_W-1:0]  i_word,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_kind,
    output logic [evt3_pkg::COL_W-1:0]   o_column,
    output logic [evt3_pkg::COL_W-1:0]   o_row,
    output logic                         o_polarity,
    output logic [evt3_pkg::TS_W-1:0]    o_timestamp,
    output logic [evt3_pkg::TYPE_W-1:0]  o_error_type,
    output logic                         o_last
);

    // Decoder state and the job for the word at the input.
    evt3_pkg::t_job w_new_job;

    // Pending job: the word currently being drained, one event per cycle while the output is not stalled.
    evt3_pkg::t_job r_job;

    logic                          w_accept;
    logic                          w_out_load;
    logic                          w_job_done;
    logic [evt3_pkg::IDX_W-1:0]    w_idx;
    logic [evt3_pkg::MASK_W-1:0]   w_mask_rest;
    logic [evt3_pkg::COL_W-1:0]    w_col;

    // Output register
    logic                          r_out_valid;
    logic                          r_kind;
    logic [evt3_pkg::COL_W-1:0]    r_column;
    logic [evt3_pkg::COL_W-1:0]    r_row;
    logic                          r_polarity;
    logic [evt3_pkg::TS_W-1:0]     r_timestamp;
    logic [evt3_pkg::TYPE_W-1:0]   r_error_type;
    logic                          r_last;

    evt3_dec_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_word   (i_word),
        .o_job    (w_new_job)
    );

    // Pick the lowest remaining mask bit; column wraps mod 2048.
    assign w_idx       = evt3_pkg::lsb_index(r_job.mask);
    assign w_mask_rest = r_job.mask & (r_job.mask - evt3_pkg::MASK_W'(1));
    assign w_col       = r_job.base + evt3_pkg::COL_W'(w_idx);

    // Output register takes a result when empty or being emptied.
    assign w_out_load = r_job.valid && (!r_out_valid || i_out_ready);
    assign w_job_done = w_out_load && (w_mask_rest == '0);

    // A new word can enter while the last event of the pending one leaves.
    assign o_in_ready = !r_job.valid || w_job_done;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job <= '0;
        end else if (w_accept) begin
            r_job <= w_new_job;
        end else if (w_out_load) begin
            r_job.valid <= (w_mask_rest != '0);
            r_job.mask  <= w_mask_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_kind       <= r_job.kind;
            // error results carry column zero
            r_column     <= (r_job.kind == evt3_pkg::K_ERROR) ? '0 : w_col;
            r_row        <= r_job.row;
            r_polarity   <= r_job.polarity;
            r_timestamp  <= r_job.timestamp;
            r_error_type <= r_job.error_type;
            r_last       <= (w_mask_rest == '0);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_column     = r_column;
    assign o_row        = r_row;
    assign o_polarity   = r_polarity;
    assign o_timestamp  = r_timestamp;
    assign o_error_type = r_error_type;
    assign o_last       = r_last;

endmodule

### design/evt3_chk.sv
module evt3_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic                         o_kind,
    input logic [evt3_pkg::COL_W-1:0]   o_column,
    input logic [evt3_pkg::COL_W-1:0]   o_row,
    input logic                         o_polarity,
    input logic [evt3_pkg::TS_W-1:0]    o_timestamp,
    input logic [evt3_pkg::TYPE_W-1:0]  o_error_type,
    input logic                         o_last
);

    // no result may survive a reset
    a_reset_clears: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

    // error results are single, zero-filled and name none of the decoded types
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == evt3_pkg::K_ERROR) |->
            (o_last && o_column == '0 && o_row == '0 && !o_polarity
             && o_timestamp == '0
             && o_error_type != evt3_pkg::T_ADDR_Y
             && o_error_type != evt3_pkg::T_ADDR_X
             && o_error_type != evt3_pkg::T_VECT_BASE_X
             && o_error_type != evt3_pkg::T_VECT_12
             && o_error_type != evt3_pkg::T_VECT_8
             && o_error_type != evt3_pkg::T_TIME_LOW
             && o_error_type != evt3_pkg::T_TIME_HIGH))
        else $error("malformed error result");

    a_event_no_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == evt3_pkg::K_EVENT) |-> o_error_type == '0)
        else $error("event result with error type");

    // the result after a non-last one shares its row, polarity and time and is an event
    a_word_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) ##1 o_out_valid |->
            (o_row == $past(o_row) && o_timestamp == $past(o_timestamp)
             && o_polarity == $past(o_polarity) && o_kind == evt3_pkg::K_EVENT))
        else $error("event group broken");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_column) && $stable(o_last)
             && $stable(o_timestamp)))
        else $error("stalled result changed");

endmodule

bind evt3_event_word_decoder_core evt3_chk u_evt3_chk (.*);
